>>> hw/rtl/smcp_pkg.sv
// ----------------------------------------------------------------------------
// smcp_pkg
// Shared types, character codes and helpers for the serial motor command
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package smcp_pkg;

	// character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_L       = 8'h4C;
	localparam logic [7:0] CH_R       = 8'h52;
	localparam logic [7:0] CH_A       = 8'h41;

	localparam logic [7:0] MAG_MAX = 8'hFF;

	// command letter taken from the first character of a line
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_LEFT  = 2'd1,
		CMD_RIGHT = 2'd2
	} cmd_t;

	// position within the line
	typedef enum logic [2:0] {
		POS_FIRST  = 3'b001,
		POS_SECOND = 3'b010,
		POS_NUMBER = 3'b100
	} pos_t;

	// progress through the number text
	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_END    = 4'b1000
	} phase_t;

	// motor speed in sign and magnitude form, minus zero never occurs
	typedef struct packed {
		logic       neg;
		logic [7:0] mag;
	} speed_t;

	typedef struct packed {
		speed_t left;
		speed_t right;
	} speeds_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/smcp_parser.sv
// ----------------------------------------------------------------------------
// smcp_parser
// Line parse state and motor speeds. Takes one character per step and gives
// the speeds that stand after it.
// ----------------------------------------------------------------------------
`default_nettype none

module smcp_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output smcp_pkg::speeds_t      speeds_next
);
	import smcp_pkg::*;

	speeds_t    speeds_q;
	pos_t       pos_q,     pos_d;
	cmd_t       cmd_q,     cmd_d;
	logic       pre_neg_q, pre_neg_d;
	phase_t     phase_q,   phase_d;
	logic       num_neg_q, num_neg_d;
	logic [7:0] acc_q,     acc_d;
	speeds_t    speeds_d;

	logic       newline;
	logic       digit;
	logic [11:0] acc_sum;
	logic [7:0]  acc_take;

	assign newline = (rx_byte == CH_NEWLINE);
	assign digit   = is_digit(rx_byte);

	// multiply by ten and add the digit, saturating
	assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {8'd0, rx_byte[3:0]};
	assign acc_take = (acc_sum > {4'd0, MAG_MAX}) ? MAG_MAX : acc_sum[7:0];

	// next state for one character
	always_comb begin
		speeds_d  = speeds_q;
		pos_d     = pos_q;
		cmd_d     = cmd_q;
		pre_neg_d = pre_neg_q;
		phase_d   = phase_q;
		num_neg_d = num_neg_q;
		acc_d     = acc_q;
		if (newline) begin
			if (cmd_q == CMD_LEFT) begin
				speeds_d.left.mag = acc_q;
				speeds_d.left.neg = (pre_neg_q ^ num_neg_q) && (acc_q != 8'd0);
			end else if (cmd_q == CMD_RIGHT) begin
				speeds_d.right.mag = acc_q;
				speeds_d.right.neg = (pre_neg_q ^ num_neg_q) && (acc_q != 8'd0);
			end
			pos_d     = POS_FIRST;
			cmd_d     = CMD_NONE;
			pre_neg_d = 1'b0;
			phase_d   = PH_SKIP;
			num_neg_d = 1'b0;
			acc_d     = 8'd0;
		end else begin
			unique case (pos_q)
				POS_FIRST: begin
					if (rx_byte == CH_L)
						cmd_d = CMD_LEFT;
					else if (rx_byte == CH_R)
						cmd_d = CMD_RIGHT;
					else
						cmd_d = CMD_NONE;
					pos_d = POS_SECOND;
				end
				POS_SECOND: begin
					pre_neg_d = (rx_byte == CH_MINUS);
					pos_d     = POS_NUMBER;
				end
				POS_NUMBER: begin
					unique case (phase_q)
						PH_SKIP: begin
							priority if (is_blank(rx_byte)) begin
								phase_d = PH_SKIP;
							end else if (rx_byte == CH_MINUS || rx_byte == CH_PLUS) begin
								num_neg_d = (rx_byte == CH_MINUS);
								phase_d   = PH_SIGN;
							end else if (digit) begin
								acc_d   = acc_take;
								phase_d = PH_DIGITS;
							end else begin
								phase_d = PH_END;
							end
						end
						PH_SIGN, PH_DIGITS: begin
							if (digit) begin
								acc_d   = acc_take;
								phase_d = PH_DIGITS;
							end else begin
								phase_d = PH_END;
							end
						end
						PH_END: begin
							phase_d = PH_END;
						end
						default: begin
							phase_d = PH_END;
						end
					endcase
				end
				default: begin
					pos_d = POS_FIRST;
				end
			endcase
		end
	end

	assign speeds_next = speeds_d;

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speeds_q  <= '0;
			pos_q     <= POS_FIRST;
			cmd_q     <= CMD_NONE;
			pre_neg_q <= 1'b0;
			phase_q   <= PH_SKIP;
			num_neg_q <= 1'b0;
			acc_q     <= 8'd0;
		end else if (step) begin
			speeds_q  <= speeds_d;
			pos_q     <= pos_d;
			cmd_q     <= cmd_d;
			pre_neg_q <= pre_neg_d;
			phase_q   <= phase_d;
			num_neg_q <= num_neg_d;
			acc_q     <= acc_d;
		end
	end

	// a magnitude is only gathered once digits have been read
	a_acc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q != 8'd0) |-> (phase_q == PH_DIGITS || phase_q == PH_END))
		else $error("magnitude held outside the digit phase");

	// a command letter is only known after the first character
	a_cmd_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != CMD_NONE) |-> (pos_q != POS_FIRST))
		else $error("command letter set at start of line");

	// no speed is ever minus zero
	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!(speeds_q.left.neg && speeds_q.left.mag == 8'd0)
		&& !(speeds_q.right.neg && speeds_q.right.mag == 8'd0))
		else $error("negative zero speed");

endmodule

`default_nettype wire

>>> hw/rtl/serial_motor_command_parser_unit.sv
// A newline item passes the input register and then the result register.
// Throughput: one item per cycle unless a newline is stalled; the single output register
// holds results, so a newline waits in the input register while a result is stalled.
// Other characters never wait on the output side.
// Reset: arst_n clears speeds to zero, the line parse state and both valids.
// ----------------------------------------------------------------------------
// serial_motor_command_parser_unit
// Parses newline-terminated L/R motor commands byte by byte and reports both
// motors' duty and direction levels on every newline.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_motor_command_parser_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      left_duty,
	output logic            left_dir_level,
	output logic [7:0]      right_duty,
	output logic            right_dir_level
);
	import smcp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       nl_s1;
	logic       out_free;
	logic       adv_s1;
	logic       out_valid_q;
	speeds_t    speeds_next;

	assign nl_s1    = (byte_s1 == CH_NEWLINE);
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!nl_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	smcp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.rx_byte     (byte_s1),
		.speeds_next (speeds_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && nl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && nl_s1) begin
			left_duty       <= speeds_next.left.mag;
			left_dir_level  <= speeds_next.left.neg;
			right_duty      <= speeds_next.right.mag;
			right_dir_level <= !speeds_next.right.neg;
		end
	end

	assign out_valid = out_valid_q;

	// only a newline held behind a full result register blocks the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && nl_s1 && out_valid_q && out_stall))
		else $error("input stalled without a pending newline");

	// a newline that moves on always produces a result
	a_nl_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && nl_s1) |=> out_valid_q)
		else $error("newline lost its result");

	// a result appears only after a newline moved on
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && nl_s1))
		else $error("result without newline");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives serial characters into the motor command parser and checks the duty
// and direction levels that it reports on every newline.
// A local line parser predicts each report and keeps a queue of pending
// reports, which a checker compares field by field as results arrive.
// Both handshakes are throttled with random bursts, and the last part of the
// run streams without any.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import smcp_pkg::*;

	// blank characters that the number text skips, besides space, tab and cr
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned GAPPED_BYTES = 1130;
	localparam int unsigned TOTAL_BYTES  = 1330;

	// one report of both motors
	typedef struct packed {
		logic [7:0] left_duty;
		logic       left_dir;
		logic [7:0] right_duty;
		logic       right_dir;
	} motor_drive_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] left_duty;
	logic       left_dir_level;
	logic [7:0] right_duty;
	logic       right_dir_level;

	bit          gaps_on      = 1'b1;
	int unsigned error_count  = 0;
	int unsigned bytes_sent   = 0;
	int unsigned quiet_cycles = 0;

	motor_drive_t pending_drives[$];

	// line parser state
	speed_t      left_spd;
	speed_t      right_spd;
	pos_t        line_pos;
	cmd_t        line_cmd;
	logic        prefix_neg;
	phase_t      num_phase;
	logic        num_neg;
	logic [7:0]  num_mag;

	serial_motor_command_parser_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.left_duty       (left_duty),
		.left_dir_level  (left_dir_level),
		.right_duty      (right_duty),
		.right_dir_level (right_dir_level)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic clear_line_state();
		line_pos   = POS_FIRST;
		line_cmd   = CMD_NONE;
		prefix_neg = 1'b0;
		num_phase  = PH_SKIP;
		num_neg    = 1'b0;
		num_mag    = 8'd0;
	endtask

	// advance the line parser by one character, queueing a report on newline
	task automatic parse_char(input logic [7:0] c);
		speed_t      spd;
		int unsigned acc;
		logic        digit;
		logic        blank;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		if (c == CH_NEWLINE) begin
			if (line_cmd != CMD_NONE) begin
				spd.mag = num_mag;
				spd.neg = (prefix_neg ^ num_neg) && (num_mag != 8'd0);
				if (line_cmd == CMD_LEFT)
					left_spd = spd;
				else
					right_spd = spd;
			end
			pending_drives.push_back('{left_spd.mag, left_spd.neg,
				right_spd.mag, !right_spd.neg});
			clear_line_state();
			return;
		end
		case (line_pos)
			POS_FIRST: begin
				if (c == CH_L)
					line_cmd = CMD_LEFT;
				else if (c == CH_R)
					line_cmd = CMD_RIGHT;
				else
					line_cmd = CMD_NONE;
				line_pos = POS_SECOND;
			end
			POS_SECOND: begin
				prefix_neg = (c == CH_MINUS);
				line_pos   = POS_NUMBER;
			end
			default: begin
				// a digit is taken in the skip, sign and digit phases alike
				if (num_phase != PH_END && digit) begin
					acc       = num_mag * 10 + (c - CH_ZERO);
					num_mag   = (acc > MAG_MAX) ? MAG_MAX : acc[7:0];
					num_phase = PH_DIGITS;
				end else if (num_phase == PH_SKIP && blank) begin
					num_phase = PH_SKIP;
				end else if (num_phase == PH_SKIP && (c == CH_MINUS || c == CH_PLUS)) begin
					num_neg   = (c == CH_MINUS);
					num_phase = PH_SIGN;
				end else begin
					num_phase = PH_END;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (error_count < 50)
			$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// send one character and wait for it to be taken
	task automatic push_char(input logic [7:0] c);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		do
			@(posedge clk);
		while (in_stall);
		parse_char(c);
		bytes_sent++;
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			push_char(s[i]);
	endtask

	// one line of random content, mostly well formed
	task automatic push_random_line();
		logic [7:0] blanks [5];
		blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
		// noise, possibly with stray newlines
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 19) == 0) begin
			push_char(CH_NEWLINE);
			return;
		end
		case ($urandom_range(0, 5))
			0, 1: push_char(CH_L);
			2, 3: push_char(CH_R);
			4:    push_char(CH_A);
			default: push_char(8'($urandom_range(0, 255)));
		endcase
		// short line
		if ($urandom_range(0, 11) == 0) begin
			push_char(CH_NEWLINE);
			return;
		end
		case ($urandom_range(0, 5))
			0, 1: push_char(CH_MINUS);
			2:    push_char(CH_PLUS);
			3:    push_char(CH_SPACE);
			4:    push_char(8'(CH_ZERO + $urandom_range(0, 9)));
			default: push_char(8'($urandom_range(0, 255)));
		endcase
		repeat ($urandom_range(0, 2)) push_char(blanks[$urandom_range(0, 4)]);
		case ($urandom_range(0, 3))
			0: push_char(CH_MINUS);
			1: push_char(CH_PLUS);
			default: ;
		endcase
		// mostly short numbers, now and then long enough to saturate
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(4, 6)) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
		else
			repeat ($urandom_range(0, 3)) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)));
		push_char(CH_NEWLINE);
	endtask

	// overlong numbers clamp at full scale
	task automatic test_saturation();
		push_text("L 999\n");
		push_text("R-255\n");
	endtask

	// prefix minus and number sign combine, and zero is never negative
	task automatic test_signs();
		push_text("R-+3\n");
		push_text("L--0\n");
	endtask

	// other letters, empty lines and a letter with no value
	task automatic test_short_lines();
		push_text("A\n");
		push_text("\n");
		push_text("R\n");
	endtask

	// a top-bit prefix, then nul ending the number early
	task automatic test_odd_bytes();
		push_char(CH_L);
		push_char(8'hFF);
		push_char(8'(CH_ZERO + 1));
		push_char(8'h00);
		push_char(8'(CH_ZERO + 2));
		push_char(CH_NEWLINE);
	endtask

	task automatic test_random_lines();
		while (bytes_sent < GAPPED_BYTES)
			push_random_line();
	endtask

	// final stretch with both sides at full rate
	task automatic test_steady_stream();
		gaps_on = 1'b0;
		while (bytes_sent < TOTAL_BYTES)
			push_random_line();
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		motor_drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drives.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_drives.pop_front();
				if (left_duty !== want.left_duty)
					report_mismatch("left_duty", left_duty, want.left_duty);
				if (left_dir_level !== want.left_dir)
					report_mismatch("left_dir_level", left_dir_level, want.left_dir);
				if (right_duty !== want.right_duty)
					report_mismatch("right_duty", right_duty, want.right_duty);
				if (right_dir_level !== want.right_dir)
					report_mismatch("right_dir_level", right_dir_level, want.right_dir);
			end
		end
	end

	// output stall bursts
	initial begin : stall_bursts
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		left_spd  = '0;
		right_spd = '0;
		clear_line_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation();
		test_signs();
		test_short_lines();
		test_odd_bytes();
		test_random_lines();
		test_steady_stream();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
